FILE: src/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// shared types and constants for the byte stream sha-256 engine
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } state_type;

   typedef logic [31:0] word_type;

   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic word_type ror32(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

FILE: src/sha256_byte_stream_hash.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hash
// sha-256 over a byte stream with padding and digest readout
// ----------------------------------------------------------------------------
//  channel | ports                                          | dir
//  req     | req_valid req_stall req_data_byte               | in
//          | req_byte_present req_end_of_message             |
//  rsp     | rsp_valid rsp_stall rsp_digest_word             | out
//          | rsp_word_index rsp_last_word                    |
//
//  a byte beat is taken while idle; a beat that fills the block runs the load,
//  round and fold states, all on the single round unit
//  an end beat pads one byte a cycle (plus a compression per full block) and
//  then shows eight digest beats, one per cycle unless rsp_stall holds them
//  req_stall is high whenever the sequencer is not idle
//  reset restores the initial hash, clears the fill count and bit count
`default_nettype none
module sha256_byte_stream_hash import sha_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire [7:0]  req_data_byte,
   input  wire        req_byte_present,
   input  wire        req_end_of_message,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0] rsp_word_index,
   output logic       rsp_last_word
);
   state_type state_ff, state_in;
   word_type  hash_ff [8];
   word_type  block_mem [16];
   word_type  sched_ff [16];
   word_type  a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   logic [5:0] fill_ff;
   logic [63:0] bits_ff, len_ff;
   logic [5:0] cnt_ff;
   logic       fin_ff;          // padding pass in progress
   logic       mark_ff;         // 0x80 marker still to place
   logic       lenblk_ff;       // current block carries the length
   logic [2:0] emit_ff;

   word_type a_nx, e_nx, w_nx, w_cur;
   logic     accept, wr_en, pad_last;
   logic [7:0] wr_byte, pad_byte;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // padding byte for the current fill position
   always_comb begin
      if (mark_ff)
         pad_byte = PAD_BYTE;
      else if (lenblk_ff && fill_ff >= LEN_START)
         pad_byte = len_ff[63:56];
      else
         pad_byte = 8'h00;
   end

   always_comb begin
      wr_en = 1'b0;
      wr_byte = pad_byte;
      if (state_ff == ST_IDLE && accept && req_byte_present) begin
         wr_en = 1'b1;
         wr_byte = req_data_byte;
      end else if (state_ff == ST_PAD) begin
         wr_en = 1'b1;
      end
   end

   assign pad_last = (fill_ff == 6'd63);
   assign w_cur = (cnt_ff < 6'd16) ? sched_ff[cnt_ff[3:0]] : w_nx;

   sha_round u_round (
      .a_i(a_ff), .b_i(b_ff), .c_i(c_ff), .d_i(d_ff),
      .e_i(e_ff), .f_i(f_ff), .g_i(g_ff), .h_i(h_ff),
      .k_i(ROUND_K[cnt_ff]), .w_i(w_cur),
      .w15_i(sched_ff[4'(cnt_ff[3:0] + 4'd1)]),
      .w2_i(sched_ff[4'(cnt_ff[3:0] + 4'd14)]),
      .w7_i(sched_ff[4'(cnt_ff[3:0] + 4'd9)]),
      .w16_i(sched_ff[cnt_ff[3:0]]),
      .a_o(a_nx), .e_o(e_nx), .wnext_o(w_nx)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_byte_present && fill_ff == 6'd63)
                  state_in = ST_LOAD;
               else if (req_end_of_message)
                  state_in = ST_PAD;
            end
         end
         ST_PAD:   state_in = pad_last ? ST_LOAD : ST_PAD;
         ST_LOAD:  state_in = (cnt_ff == 6'd15) ? ST_ROUND : ST_LOAD;
         ST_ROUND: state_in = (cnt_ff == 6'd63) ? ST_FOLD : ST_ROUND;
         ST_FOLD: begin
            if (fin_ff && lenblk_ff)
               state_in = ST_EMIT;
            else if (fin_ff)
               state_in = ST_PAD;
            else
               state_in = ST_IDLE;
         end
         ST_EMIT:  state_in = (emit_ff == 3'd7 && !rsp_stall) ? ST_IDLE : ST_EMIT;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rsp_valid = (state_ff == ST_EMIT);
      rsp_digest_word = hash_ff[emit_ff];
      rsp_word_index = emit_ff;
      rsp_last_word = (emit_ff == 3'd7);
   end

   // byte lanes, first byte of a word in the top lane
   always_ff @(posedge clock) begin
      if (wr_en)
         block_mem[fill_ff[5:2]][{~fill_ff[1:0], 3'b111} -: 8] <= wr_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         bits_ff <= '0;
         cnt_ff <= '0;
         fin_ff <= 1'b0;
         mark_ff <= 1'b0;
         lenblk_ff <= 1'b0;
         emit_ff <= '0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= INIT_HASH[i];
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (accept) begin
                  if (req_byte_present) begin
                     fill_ff <= fill_ff + 6'd1;
                     bits_ff <= bits_ff + 64'd8;
                  end
                  if (req_end_of_message) begin
                     fin_ff <= 1'b1;
                     // 0x80 goes in on the pad pass
                     mark_ff <= 1'b1;
                     lenblk_ff <= 1'b0;
                     len_ff <= req_byte_present ? bits_ff + 64'd8 : bits_ff;
                  end
               end
            end
            ST_PAD: begin
               fill_ff <= fill_ff + 6'd1;
               if (mark_ff) begin
                  mark_ff <= 1'b0;
                  // length fits behind the marker only below byte 56
                  lenblk_ff <= (fill_ff < LEN_START);
               end else if (lenblk_ff && fill_ff >= LEN_START) begin
                  len_ff <= {len_ff[55:0], 8'h00};
               end
            end
            ST_LOAD: begin
               sched_ff[cnt_ff[3:0]] <= block_mem[cnt_ff[3:0]];
               cnt_ff <= (cnt_ff == 6'd15) ? 6'd0 : cnt_ff + 6'd1;
               if (cnt_ff == 6'd0) begin
                  a_ff <= hash_ff[0]; b_ff <= hash_ff[1];
                  c_ff <= hash_ff[2]; d_ff <= hash_ff[3];
                  e_ff <= hash_ff[4]; f_ff <= hash_ff[5];
                  g_ff <= hash_ff[6]; h_ff <= hash_ff[7];
               end
            end
            ST_ROUND: begin
               if (cnt_ff >= 6'd16)
                  sched_ff[cnt_ff[3:0]] <= w_nx;
               h_ff <= g_ff; g_ff <= f_ff; f_ff <= e_ff; e_ff <= e_nx;
               d_ff <= c_ff; c_ff <= b_ff; b_ff <= a_ff; a_ff <= a_nx;
               cnt_ff <= cnt_ff + 6'd1;
            end
            ST_FOLD: begin
               hash_ff[0] <= hash_ff[0] + a_ff; hash_ff[1] <= hash_ff[1] + b_ff;
               hash_ff[2] <= hash_ff[2] + c_ff; hash_ff[3] <= hash_ff[3] + d_ff;
               hash_ff[4] <= hash_ff[4] + e_ff; hash_ff[5] <= hash_ff[5] + f_ff;
               hash_ff[6] <= hash_ff[6] + g_ff; hash_ff[7] <= hash_ff[7] + h_ff;
               fill_ff <= '0;
               if (fin_ff) begin
                  if (lenblk_ff) begin
                     fin_ff <= 1'b0;
                     lenblk_ff <= 1'b0;
                  end else if (!mark_ff) begin
                     // marker landed past byte 55: length goes in the next block
                     lenblk_ff <= 1'b1;
                  end
               end
               emit_ff <= '0;
            end
            ST_EMIT: begin
               if (!rsp_stall) begin
                  emit_ff <= emit_ff + 3'd1;
                  if (emit_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) hash_ff[i] <= INIT_HASH[i];
                     fill_ff <= '0;
                     bits_ff <= '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   property p_stall_busy;
      @(posedge clock) disable iff (reset) (state_ff != ST_IDLE) |-> req_stall;
   endproperty
   a_stall_busy: assert property (p_stall_busy) else $error("req not stalled while busy");

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last word flag mismatch");

   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rsp_valid) else $error("rsp while idle");

endmodule
`default_nettype wire

FILE: src/sha_round.sv
// ----------------------------------------------------------------------------
// sha_round
// one sha-256 compression round and schedule step, reused for all 64 rounds
// ----------------------------------------------------------------------------
`default_nettype none
module sha_round import sha_pkg::*; (
   input  wire word_type      a_i, b_i, c_i, d_i, e_i, f_i, g_i, h_i,
   input  wire word_type      k_i,
   input  wire word_type      w_i,
   input  wire word_type      w15_i, w2_i, w7_i, w16_i,
   output word_type           a_o, e_o,
   output word_type           wnext_o
);
   word_type t1, t2, s0, s1;

   always_comb begin
      s0 = ror32(w15_i, 7) ^ ror32(w15_i, 18) ^ (w15_i >> 3);
      s1 = ror32(w2_i, 17) ^ ror32(w2_i, 19) ^ (w2_i >> 10);
      wnext_o = w16_i + s0 + w7_i + s1;
      t1 = h_i + (ror32(e_i, 6) ^ ror32(e_i, 11) ^ ror32(e_i, 25)) +
           ((e_i & f_i) ^ (~e_i & g_i)) + k_i + w_i;
      t2 = (ror32(a_i, 2) ^ ror32(a_i, 13) ^ ror32(a_i, 22)) +
           ((a_i & b_i) ^ (a_i & c_i) ^ (b_i & c_i));
      e_o = d_i + t1;
      a_o = t1 + t2;
   end
endmodule
`default_nettype wire
